>>> rtl/core/csa_pkg.sv
// Package for the contiguous segment allocator: field widths, codes,
// segment entry and controller/datapath command and status types.
// No dependencies.
package csa_pkg;

   localparam int ADDR_W  = 20;
   localparam int SIZE_W  = 21;
   localparam int OWNER_W = 16;
   localparam int FUNC_W  = 2;
   localparam int STRAT_W = 2;
   localparam int STAT_W  = 3;

   localparam logic [SIZE_W-1:0] MEM_DEFAULT = 21'd128;
   localparam logic [SIZE_W-1:0] MEM_LIMIT   = 21'd1048576;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPACT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_BAD     = 2'd3;

   localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
   localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
   localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;
   localparam logic [STRAT_W-1:0] STRAT_BAD   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOOWNER  = 3'd2;
   localparam logic [STAT_W-1:0] ST_BADSTRAT = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [SIZE_W-1:0]  size;
      logic               used;
      logic [OWNER_W-1:0] owner;
   } seg_type;

   localparam int SEG_W = $bits(seg_type);

   typedef struct packed {
      logic init;
      logic start;
      logic scan;
      logic shift_init;
      logic shift;
      logic wr_split;
      logic wr_pick;
      logic tail;
   } cmd_type;

   typedef struct packed {
      logic               scan_done;
      logic               shift_done;
      logic               found;
      logic               exact;
      logic               full;
      logic               req_zero;
      logic [FUNC_W-1:0]  func;
      logic [STRAT_W-1:0] strat;
      logic [ADDR_W-1:0]  pick_start;
      logic [ADDR_W-1:0]  next_addr;
   } stat_type;

endpackage

>>> rtl/core/csa_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on csa_pkg.
interface csa_req_if;
   logic                         valid;
   logic                         ready;
   logic [csa_pkg::FUNC_W-1:0]   func;
   logic [csa_pkg::OWNER_W-1:0]  owner_id;
   logic [csa_pkg::SIZE_W-1:0]   request_size;
   logic [csa_pkg::STRAT_W-1:0]  fit_strategy;
   modport source (output valid, func, owner_id, request_size, fit_strategy, input ready);
   modport sink (input valid, func, owner_id, request_size, fit_strategy, output ready);
endinterface

interface csa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [csa_pkg::STAT_W-1:0]  status;
   logic [csa_pkg::ADDR_W-1:0]  address;
   modport source (output valid, status, address, input ready);
   modport sink (input valid, status, address, output ready);
endinterface

>>> rtl/core/contiguous_segment_allocator_core.sv
// An item is taken in S_IDLE, scanned in S_SCAN (one RAM read per cycle), judged in
// S_DECIDE; a release or exact fit writes S_PICK, a split shifts in S_SHIFT, then
// writes S_SPLIT and S_PICK; S_DONE registers the result. One item at a time: the next
// item is taken in the cycle after the result is registered, while that result may
// still wait. Reset (synchronous) and each size register write rebuild the table to one
// free segment; no item is taken after the write until the rebuild is done.
module contiguous_segment_allocator_core #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [csa_pkg::SIZE_W-1:0]  csr_write_data,
   csa_req_if.sink                     req_if,
   csa_rsp_if.source                   rsp_if
);
   csa_pkg::cmd_type  cmd;
   csa_pkg::stat_type stat;

   csa_controller u_ctrl (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .rsp_status(rsp_if.status),
      .rsp_address(rsp_if.address),
      .cmd(cmd),
      .stat(stat)
   );

   csa_datapath #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .in_func(req_if.func),
      .in_owner(req_if.owner_id),
      .in_size(req_if.request_size),
      .in_strat(req_if.fit_strategy),
      .cmd(cmd),
      .stat(stat)
   );
endmodule

>>> rtl/core/csa_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module csa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/csa_datapath.sv
// Segment table datapath: table RAM, scan/shift cursors, pick registers.
// Depends on csa_pkg and csa_ram.
module csa_datapath #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [csa_pkg::SIZE_W-1:0]   csr_write_data,
   input  logic [csa_pkg::FUNC_W-1:0]   in_func,
   input  logic [csa_pkg::OWNER_W-1:0]  in_owner,
   input  logic [csa_pkg::SIZE_W-1:0]   in_size,
   input  logic [csa_pkg::STRAT_W-1:0]  in_strat,
   input  csa_pkg::cmd_type             cmd,
   output csa_pkg::stat_type            stat
);
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

   logic [csa_pkg::SIZE_W-1:0]  mem_size_ff, mem_size_in;
   logic [csa_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [csa_pkg::OWNER_W-1:0] owner_ff, owner_in;
   logic [csa_pkg::SIZE_W-1:0]  req_ff, req_in;
   logic [csa_pkg::STRAT_W-1:0] strat_ff, strat_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] eval_idx_ff, eval_idx_in;
   logic [CW-1:0] pick_ff, pick_in;
   logic [CW-1:0] w_ff, w_in;
   logic          eval_ff, eval_in;
   logic          found_ff, found_in;
   logic [csa_pkg::ADDR_W-1:0]  pick_start_ff, pick_start_in;
   logic [csa_pkg::SIZE_W-1:0]  pick_size_ff, pick_size_in;
   logic [csa_pkg::SIZE_W-1:0]  next_ff, next_in;

   logic                 we;
   logic [IW-1:0]        waddr, raddr;
   csa_pkg::seg_type     wdata, rd;
   logic [csa_pkg::SEG_W-1:0] rdata;
   logic [csa_pkg::SIZE_W-1:0] csr_value;
   logic [CW-1:0]        pick_next;
   logic                 take;

   assign rd = csa_pkg::seg_type'(rdata);
   assign pick_next = CW'(pick_ff + 1'b1);

   always_comb begin
      csr_value = csr_write_data;
      if (csr_write_data == '0 || csr_write_data > csa_pkg::MEM_LIMIT) begin
         csr_value = csa_pkg::MEM_DEFAULT;
      end
   end

   always_comb begin
      mem_size_in = csr_write_enable ? csr_value : mem_size_ff;
      func_in = func_ff;
      owner_in = owner_ff;
      req_in = req_ff;
      strat_in = strat_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      eval_idx_in = eval_idx_ff;
      pick_in = pick_ff;
      w_in = w_ff;
      eval_in = eval_ff;
      found_in = found_ff;
      pick_start_in = pick_start_ff;
      pick_size_in = pick_size_ff;
      next_in = next_ff;
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      raddr = '0;
      take = 1'b0;

      if (cmd.init) begin
         we = 1'b1;
         wdata.size = mem_size_ff;
         count_in = CW'(1);
      end

      if (cmd.start) begin
         func_in = in_func;
         owner_in = in_owner;
         req_in = in_size;
         strat_in = in_strat;
         idx_in = '0;
         eval_in = 1'b0;
         found_in = 1'b0;
         next_in = '0;
         w_in = '0;
      end

      if (cmd.scan) begin
         eval_in = idx_ff < count_ff;
         raddr = idx_ff[IW-1:0];
         eval_idx_in = idx_ff;
         if (idx_ff < count_ff) begin
            idx_in = CW'(idx_ff + 1'b1);
         end
         if (eval_ff) begin
            case (func_ff)
               csa_pkg::FUNC_ALLOC: begin
                  if (!rd.used && rd.size >= req_ff) begin
                     take = !found_ff
                        || (strat_ff == csa_pkg::STRAT_BEST && rd.size < pick_size_ff)
                        || (strat_ff == csa_pkg::STRAT_WORST && rd.size > pick_size_ff);
                  end
               end
               csa_pkg::FUNC_RELEASE: begin
                  take = rd.used && rd.owner == owner_ff && !found_ff;
               end
               csa_pkg::FUNC_COMPACT: begin
                  if (rd.used) begin
                     we = 1'b1;
                     waddr = w_ff[IW-1:0];
                     wdata.start = next_ff[csa_pkg::ADDR_W-1:0];
                     wdata.size = rd.size;
                     wdata.used = 1'b1;
                     wdata.owner = rd.owner;
                     next_in = csa_pkg::SIZE_W'(next_ff + rd.size);
                     w_in = CW'(w_ff + 1'b1);
                  end
               end
               default: begin
                  take = 1'b0;
               end
            endcase
            if (take) begin
               found_in = 1'b1;
               pick_in = eval_idx_ff;
               pick_start_in = rd.start;
               pick_size_in = rd.size;
            end
         end
      end

      if (cmd.shift_init) begin
         idx_in = count_ff;
         eval_in = 1'b0;
      end

      if (cmd.shift) begin
         eval_in = idx_ff > pick_next;
         if (idx_ff > pick_next) begin
            raddr = IW'(idx_ff - 1'b1);
            eval_idx_in = idx_ff;
            idx_in = CW'(idx_ff - 1'b1);
         end
         if (eval_ff) begin
            we = 1'b1;
            waddr = eval_idx_ff[IW-1:0];
            wdata = rd;
         end
      end

      if (cmd.wr_split) begin
         we = 1'b1;
         waddr = pick_next[IW-1:0];
         wdata.start = csa_pkg::ADDR_W'(pick_start_ff + req_ff[csa_pkg::ADDR_W-1:0]);
         wdata.size = csa_pkg::SIZE_W'(pick_size_ff - req_ff);
         count_in = CW'(count_ff + 1'b1);
      end

      if (cmd.wr_pick) begin
         we = 1'b1;
         waddr = pick_ff[IW-1:0];
         wdata.start = pick_start_ff;
         if (func_ff == csa_pkg::FUNC_ALLOC) begin
            wdata.size = req_ff;
            wdata.used = 1'b1;
            wdata.owner = owner_ff;
         end else begin
            wdata.size = pick_size_ff;
         end
      end

      if (cmd.tail) begin
         count_in = w_ff;
         if (next_ff < mem_size_ff && w_ff < MAX_C) begin
            we = 1'b1;
            waddr = w_ff[IW-1:0];
            wdata.start = next_ff[csa_pkg::ADDR_W-1:0];
            wdata.size = csa_pkg::SIZE_W'(mem_size_ff - next_ff);
            count_in = CW'(w_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff <= csa_pkg::MEM_DEFAULT;
         count_ff <= CW'(1);
         eval_ff <= 1'b0;
         found_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         mem_size_ff <= mem_size_in;
         count_ff <= count_in;
         eval_ff <= eval_in;
         found_ff <= found_in;
         idx_ff <= idx_in;
      end
      func_ff <= func_in;
      owner_ff <= owner_in;
      req_ff <= req_in;
      strat_ff <= strat_in;
      eval_idx_ff <= eval_idx_in;
      pick_ff <= pick_in;
      w_ff <= w_in;
      pick_start_ff <= pick_start_in;
      pick_size_ff <= pick_size_in;
      next_ff <= next_in;
   end

   csa_ram #(
      .WIDTH(csa_pkg::SEG_W),
      .DEPTH(MAX_SEGMENTS)
   ) u_table (
      .clock(clock),
      .wr_en(we),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   always_comb begin
      stat.scan_done = !(idx_ff < count_ff) && !eval_ff;
      stat.shift_done = !(idx_ff > pick_next) && !eval_ff;
      stat.found = found_ff;
      stat.exact = pick_size_ff == req_ff;
      stat.full = count_ff >= MAX_C;
      stat.req_zero = req_ff == '0;
      stat.func = func_ff;
      stat.strat = strat_ff;
      stat.pick_start = pick_start_ff;
      stat.next_addr = next_ff[csa_pkg::ADDR_W-1:0];
   end
endmodule

>>> rtl/core/csa_controller.sv
// Allocator sequencer: operation state machine and response register.
// Depends on csa_pkg.
module csa_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [csa_pkg::STAT_W-1:0]  rsp_status,
   output logic [csa_pkg::ADDR_W-1:0]  rsp_address,
   output csa_pkg::cmd_type            cmd,
   input  csa_pkg::stat_type           stat
);
   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_SPLIT  = 3'd5;
   localparam logic [2:0] S_PICK   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       init_pend_ff, init_pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [csa_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in, res_status_ff, res_status_in;
   logic [csa_pkg::ADDR_W-1:0] rsp_address_ff, rsp_address_in, res_addr_ff, res_addr_in;

   assign req_ready = state_ff == S_IDLE && !init_pend_ff;

   always_comb begin
      state_in = state_ff;
      init_pend_in = init_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_address_in = rsp_address_ff;
      res_status_in = res_status_ff;
      res_addr_in = res_addr_ff;
      cmd = '0;

      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            init_pend_in = 1'b0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (init_pend_ff) begin
               state_in = S_INIT;
            end else if (req_valid) begin
               cmd.start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_addr_in = '0;
            state_in = S_DONE;
            case (stat.func)
               csa_pkg::FUNC_ALLOC: begin
                  if (stat.strat == csa_pkg::STRAT_BAD) begin
                     res_status_in = csa_pkg::ST_BADSTRAT;
                  end else if (stat.req_zero || !stat.found) begin
                     res_status_in = csa_pkg::ST_NOFIT;
                  end else if (stat.exact) begin
                     res_status_in = csa_pkg::ST_OK;
                     res_addr_in = stat.pick_start;
                     state_in = S_PICK;
                  end else if (stat.full) begin
                     res_status_in = csa_pkg::ST_FULL;
                  end else begin
                     res_status_in = csa_pkg::ST_OK;
                     res_addr_in = stat.pick_start;
                     cmd.shift_init = 1'b1;
                     state_in = S_SHIFT;
                  end
               end
               csa_pkg::FUNC_RELEASE: begin
                  if (stat.found) begin
                     res_status_in = csa_pkg::ST_OK;
                     res_addr_in = stat.pick_start;
                     state_in = S_PICK;
                  end else begin
                     res_status_in = csa_pkg::ST_NOOWNER;
                  end
               end
               csa_pkg::FUNC_COMPACT: begin
                  cmd.tail = 1'b1;
                  res_status_in = csa_pkg::ST_OK;
                  res_addr_in = stat.next_addr;
               end
               default: begin
                  res_status_in = csa_pkg::ST_BADSTRAT;
               end
            endcase
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            cmd.wr_split = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.wr_pick = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_address_in = res_addr_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         init_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_pend_ff <= init_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_address_ff <= rsp_address_in;
      res_status_ff <= res_status_in;
      res_addr_ff <= res_addr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_address = rsp_address_ff;
endmodule

>>> rtl/core/csa_checker.sv
// Port-level checks for the allocator core, attached by bind.
// Depends on csa_pkg and contiguous_segment_allocator_core.
module csa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_write_enable,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [csa_pkg::STAT_W-1:0]  rsp_status,
   input logic [csa_pkg::ADDR_W-1:0]  rsp_address
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= csa_pkg::ST_FULL)
      else $error("status code out of range");

   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != csa_pkg::ST_OK |-> rsp_address == '0)
      else $error("nonzero address on failed item");

   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_ready)
      else $error("item taken before table rebuild");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind contiguous_segment_allocator_core csa_checker u_csa_checker (
   .clock(clock),
   .reset(reset),
   .csr_write_enable(csr_write_enable),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_status(rsp_if.status),
   .rsp_address(rsp_if.address)
);

>>> tb/csa_checker.sv
`timescale 1ns / 100ps
// Checker for the contiguous segment allocator: keeps its own segment table,
// predicts each response and compares it. Depends on csa_pkg and csa_if.
module csa_scoreboard (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [csa_pkg::SIZE_W-1:0] csr_write_data,
   csa_req_if                         req_if,
   csa_rsp_if                         rsp_if,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [csa_pkg::STAT_W-1:0] status;
      logic [csa_pkg::ADDR_W-1:0] address;
   } alloc_result_type;

   localparam int TABLE_DEPTH = 64;

   alloc_result_type           expected_responses[$];
   logic [csa_pkg::SIZE_W-1:0] mem_size;
   csa_pkg::seg_type           seg_table[TABLE_DEPTH];
   int                         seg_count;

   initial begin
      fail_count = 0;
      pending = 0;
      mem_size = csa_pkg::MEM_DEFAULT;
      seg_count = 1;
   end

   function automatic void rebuild_table();
      seg_table[0] = '{start: '0, size: mem_size, used: 1'b0, owner: '0};
      seg_count = 1;
   endfunction

   function automatic alloc_result_type allocate(logic [csa_pkg::OWNER_W-1:0] owner,
                                                 logic [csa_pkg::SIZE_W-1:0] req,
                                                 logic [csa_pkg::STRAT_W-1:0] strat);
      alloc_result_type r;
      int pick;
      bit found;
      r = '{status: csa_pkg::ST_OK, address: '0};
      pick = 0;
      found = 0;
      if (strat == csa_pkg::STRAT_BAD) begin
         r.status = csa_pkg::ST_BADSTRAT;
         return r;
      end
      if (req == 0) begin
         r.status = csa_pkg::ST_NOFIT;
         return r;
      end
      for (int i = 0; i < seg_count; i++) begin
         if (seg_table[i].used || seg_table[i].size < req) continue;
         if (!found) begin
            pick = i;
            found = 1;
            if (strat == csa_pkg::STRAT_FIRST) break;
         end else if (strat == csa_pkg::STRAT_BEST
                      && seg_table[i].size < seg_table[pick].size) begin
            pick = i;
         end else if (strat == csa_pkg::STRAT_WORST
                      && seg_table[i].size > seg_table[pick].size) begin
            pick = i;
         end
      end
      if (!found) begin
         r.status = csa_pkg::ST_NOFIT;
         return r;
      end
      if (seg_table[pick].size != req) begin
         if (seg_count >= TABLE_DEPTH) begin
            r.status = csa_pkg::ST_FULL;
            return r;
         end
         for (int i = seg_count; i > pick + 1; i--) seg_table[i] = seg_table[i-1];
         seg_table[pick+1].start = seg_table[pick].start + req[csa_pkg::ADDR_W-1:0];
         seg_table[pick+1].size  = seg_table[pick].size - req;
         seg_table[pick+1].used  = 1'b0;
         seg_table[pick+1].owner = '0;
         seg_table[pick].size = req;
         seg_count++;
      end
      seg_table[pick].used = 1'b1;
      seg_table[pick].owner = owner;
      r.address = seg_table[pick].start;
      return r;
   endfunction

   function automatic alloc_result_type release_owner(logic [csa_pkg::OWNER_W-1:0] owner);
      alloc_result_type r;
      r = '{status: csa_pkg::ST_NOOWNER, address: '0};
      for (int i = 0; i < seg_count; i++) begin
         if (seg_table[i].used && seg_table[i].owner == owner) begin
            seg_table[i].used = 1'b0;
            seg_table[i].owner = '0;
            r.status = csa_pkg::ST_OK;
            r.address = seg_table[i].start;
            return r;
         end
      end
      return r;
   endfunction

   function automatic alloc_result_type compact();
      alloc_result_type r;
      int w;
      logic [csa_pkg::SIZE_W-1:0] next;
      w = 0;
      next = '0;
      for (int i = 0; i < seg_count; i++) begin
         if (!seg_table[i].used) continue;
         seg_table[w].start = next[csa_pkg::ADDR_W-1:0];
         seg_table[w].size  = seg_table[i].size;
         seg_table[w].used  = 1'b1;
         seg_table[w].owner = seg_table[i].owner;
         next = next + seg_table[i].size;
         w++;
      end
      if (next < mem_size && w < TABLE_DEPTH) begin
         seg_table[w] = '{start: next[csa_pkg::ADDR_W-1:0], size: mem_size - next,
                          used: 1'b0, owner: '0};
         w++;
      end
      seg_count = w;
      r.status = csa_pkg::ST_OK;
      r.address = next[csa_pkg::ADDR_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: response mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      alloc_result_type got;
      if (reset) begin
         mem_size = csa_pkg::MEM_DEFAULT;
         rebuild_table();
         expected_responses.delete();
      end else begin
         if (csr_write_enable) begin
            mem_size = (csr_write_data == 0 || csr_write_data > csa_pkg::MEM_LIMIT) ?
                       csa_pkg::MEM_DEFAULT : csr_write_data;
            rebuild_table();
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{status: rsp_if.status, address: rsp_if.address};
            if (expected_responses.size() == 0) begin
               report_mismatch("outstanding count", 1, 0);
            end else begin
               want = expected_responses.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.address != want.address)
                  report_mismatch("address", got.address, want.address);
            end
         end
         if (req_if.valid && req_if.ready) begin
            case (req_if.func)
               csa_pkg::FUNC_ALLOC: want = allocate(req_if.owner_id, req_if.request_size,
                                                    req_if.fit_strategy);
               csa_pkg::FUNC_RELEASE: want = release_owner(req_if.owner_id);
               csa_pkg::FUNC_COMPACT: want = compact();
               default: want = '{status: csa_pkg::ST_BADSTRAT, address: '0};
            endcase
            expected_responses.push_back(want);
         end
      end
      pending = expected_responses.size();
   end

endmodule

>>> tb/contiguous_segment_allocator_core_test.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and response traffic, memory size
// writes and verdict. Depends on csa_pkg, csa_if, csa_checker and the allocator core.
module contiguous_segment_allocator_core_test;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [csa_pkg::SIZE_W-1:0] csr_write_data;
   int                         fail_count;
   int                         pending;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         alloc_pct;
   logic [csa_pkg::SIZE_W-1:0] mem_size;
   bit                         hold_request;
   bit                         hold_ack;
   int                         hold_left;

   csa_req_if req_ch();
   csa_rsp_if rsp_ch();

   contiguous_segment_allocator_core uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   csa_scoreboard checker_inst (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("contiguous_segment_allocator_core regression: fail");
      $finish;
   end

   initial begin
      hold_left = 0;
      hold_ack = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_request != hold_ack) begin
         hold_ack <= hold_request;
         hold_left <= 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(logic [csa_pkg::FUNC_W-1:0] func,
                            logic [csa_pkg::OWNER_W-1:0] owner,
                            logic [csa_pkg::SIZE_W-1:0] size,
                            logic [csa_pkg::STRAT_W-1:0] strat);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.owner_id <= owner;
      req_ch.request_size <= size;
      req_ch.fit_strategy <= strat;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_random_item();
      int r;
      logic [csa_pkg::FUNC_W-1:0] func;
      logic [csa_pkg::OWNER_W-1:0] owner;
      logic [csa_pkg::SIZE_W-1:0] size;
      logic [csa_pkg::STRAT_W-1:0] strat;
      r = $urandom_range(99);
      if (r < alloc_pct) func = csa_pkg::FUNC_ALLOC;
      else if (r < 90) func = csa_pkg::FUNC_RELEASE;
      else if (r < 96) func = csa_pkg::FUNC_COMPACT;
      else func = csa_pkg::FUNC_BAD;
      owner = ($urandom_range(99) < 85) ? csa_pkg::OWNER_W'($urandom_range(7))
                                        : csa_pkg::OWNER_W'($urandom_range(16'hFFFF));
      r = $urandom_range(99);
      if (r < 4) size = '0;
      else if (r < 9) size = csa_pkg::SIZE_W'($urandom_range(21'h1FFFFF));
      else if (r < 13) size = mem_size;
      else if (r < 60) size = csa_pkg::SIZE_W'($urandom_range(1, 4));
      else size = csa_pkg::SIZE_W'($urandom_range(1, (mem_size > 8) ? mem_size / 8 : 1));
      strat = ($urandom_range(99) < 5) ? csa_pkg::STRAT_BAD
                                       : csa_pkg::STRAT_W'($urandom_range(2));
      send_item(func, owner, size, strat);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_mem_size(logic [csa_pkg::SIZE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      mem_size <= (value == 0 || value > csa_pkg::MEM_LIMIT) ? csa_pkg::MEM_DEFAULT : value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [csa_pkg::SIZE_W-1:0] sizes[6];
      sizes = '{21'd128, 21'd1, 21'd1048576, 21'd0, 21'h1FFFFF, 21'd0};
      sizes[5] = csa_pkg::SIZE_W'($urandom_range(2, 5000));
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.func <= csa_pkg::FUNC_ALLOC;
      req_ch.owner_id <= '0;
      req_ch.request_size <= '0;
      req_ch.fit_strategy <= csa_pkg::STRAT_FIRST;
      hold_request <= 1'b0;
      mem_size <= csa_pkg::MEM_DEFAULT;
      send_idle_pct <= 36;
      recv_idle_pct <= 72;
      alloc_pct <= 60;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(csa_pkg::FUNC_ALLOC, 16'd0, 21'd1, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_ALLOC, 16'hFFFF, 21'd10, csa_pkg::STRAT_BEST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd5, 21'd20, csa_pkg::STRAT_WORST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd6, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd6, 21'h1FFFFF, csa_pkg::STRAT_BEST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd6, 21'd128, csa_pkg::STRAT_WORST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd6, 21'd4, csa_pkg::STRAT_BAD);
      send_item(csa_pkg::FUNC_BAD, 16'd6, 21'd4, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'd0, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'd1234, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd7, 21'd1, csa_pkg::STRAT_BEST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd8, 21'd2, csa_pkg::STRAT_WORST);
      send_item(csa_pkg::FUNC_COMPACT, 16'd0, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'hFFFF, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'd5, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_COMPACT, 16'd0, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'd7, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'd8, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_COMPACT, 16'd0, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_ALLOC, 16'd1, 21'd128, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_COMPACT, 16'd0, 21'd0, csa_pkg::STRAT_FIRST);
      send_item(csa_pkg::FUNC_RELEASE, 16'd1, 21'd0, csa_pkg::STRAT_FIRST);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct <= (phase < 2) ? 36 : (phase < 4) ? 72 : 0;
         recv_idle_pct <= (phase < 2) ? 72 : (phase < 4) ? 36 : 0;
         alloc_pct <= (phase == 0) ? 85 : 60;
         write_mem_size(sizes[phase]);
         if (phase == 0) hold_request <= ~hold_request;
         for (int n = 0; n < 64; n++) send_random_item();
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("contiguous_segment_allocator_core regression: pass");
      end else begin
         $display("contiguous_segment_allocator_core regression: fail");
      end
      $finish;
   end

endmodule
